[hdl/cmwc4096_random_generator_macros.svh]
`ifndef CMWC4096_RANDOM_GENERATOR_MACROS_SVH
`define CMWC4096_RANDOM_GENERATOR_MACROS_SVH

// same-cycle implication, checked while out of reset
`define CMWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define CMWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cmwc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

  localparam int STREAMS  = 4;
  localparam int STREAM_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;

  localparam int LAG_LEN   = 4096;
  localparam int IDX_W     = 12;
  localparam int LAG_DEPTH = STREAMS * LAG_LEN;
  localparam int ADDR_W    = $clog2(LAG_DEPTH);

  localparam logic [IDX_W-1:0] LAG_MASK   = IDX_W'(LAG_LEN - 1);
  localparam logic [15:0]      GEN_MULT   = 16'd18782;
  localparam logic [31:0]      GEN_R      = 32'hffff_fffe;
  localparam logic [31:0]      INIT_MULT  = 32'd1812433253;
  localparam logic [31:0]      CARRY_MOD  = 32'd809430660;
  localparam int               INIT_SHIFT = 30;
  localparam int               PROD_W     = 48;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [1:0]          op_t;
  typedef logic [STREAM_W-1:0] stream_t;

  localparam op_t OP_GEN  = 2'd0;
  localparam op_t OP_SEED = 2'd1;
  localparam op_t OP_NOP  = 2'd2;

  typedef struct packed {
    op_t         op;
    stream_t     stream;
    logic [31:0] seed;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/cmwc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  addr,
  input  wire  [WIDTH-1:0]          wdata,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[hdl/cmwc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cmwc_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  wire              in_req_type,
  input  wire  [1:0]       in_stream_id,
  input  wire  [31:0]      in_seed_value,
  output logic             head_valid,
  output cmwc_pkg::cmd_t   head_cmd,
  input  wire              head_pop
);

  import cmwc_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [7:0]        sid_ext;
  logic              in_range;
  logic              accept;
  cmd_t              in_cmd;

  // classify: out-of-range streams become a no-op that still answers
  always_comb begin
    sid_ext       = 8'(in_stream_id);
    in_range      = (sid_ext < 8'(STREAMS));
    in_cmd.stream = STREAM_W'(sid_ext);
    in_cmd.seed   = in_seed_value;
    if (!in_range) begin
      in_cmd.op = OP_NOP;
    end else if (in_req_type) begin
      in_cmd.op = OP_SEED;
    end else begin
      in_cmd.op = OP_GEN;
    end
  end

  assign busy       = (count_r == QCNT_W'(QDEPTH));
  assign accept     = start && !busy;
  assign head_valid = (count_r != '0);
  assign head_cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = head_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(accept) - QCNT_W'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

[hdl/cmwc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "cmwc4096_random_generator_macros.svh"

module cmwc_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    head_valid,
  input  wire  cmwc_pkg::cmd_t   head_cmd,
  output logic                   head_pop,
  output logic                   out_valid,
  output logic [31:0]            out_random_word,
  output logic                   out_seed_done
);

  import cmwc_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEED_MUL = 3'd1;
  localparam logic [2:0] ST_SEED_ADD = 3'd2;
  localparam logic [2:0] ST_SEED_MOD = 3'd3;
  localparam logic [2:0] ST_GEN_MUL  = 3'd4;
  localparam logic [2:0] ST_GEN_ADD  = 3'd5;
  localparam logic [2:0] ST_GEN_FIN  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  stream_t           s_r, s_nxt;
  logic [31:0]       w_r, w_nxt;
  logic [31:0]       p_r, p_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  gidx_r, gidx_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] t_r, t_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_random_word_r, out_word_nxt;
  logic              out_seed_done_r, out_seed_nxt;

  logic [31:0]       carry_r   [STREAMS];
  logic [IDX_W-1:0]  lag_idx_r [STREAMS];
  logic              st_we;
  logic [31:0]       carry_set;
  logic [IDX_W-1:0]  idx_set;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;

  logic [31:0]       mix;
  logic [31:0]       mul_lo;
  logic [31:0]       seed_w;
  logic [IDX_W-1:0]  next_idx;
  logic [31:0]       c_raw;
  logic [31:0]       x_raw;
  logic              wrap;
  logic [31:0]       x_fix;
  logic [31:0]       c_fix;
  logic [31:0]       gen_word;

  cmwc_ram #(
    .WIDTH (32),
    .DEPTH (LAG_DEPTH)
  ) u_lag_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    mix      = w_r ^ (w_r >> INIT_SHIFT);
    mul_lo   = INIT_MULT * mix;
    seed_w   = p_r + 32'(j_r);
    next_idx = lag_idx_r[head_cmd.stream] + IDX_W'(1);
    // carry fixup: the wrapped sum is bumped along with the carry
    c_raw    = 32'(t_r[PROD_W-1:32]);
    x_raw    = t_r[31:0] + c_raw;
    wrap     = (x_raw < c_raw);
    x_fix    = x_raw + 32'(wrap);
    c_fix    = c_raw + 32'(wrap);
    gen_word = GEN_R - x_fix;
  end

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    w_nxt         = w_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    gidx_nxt      = gidx_r;
    prod_nxt      = prod_r;
    t_nxt         = t_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_random_word_r;
    out_seed_nxt  = out_seed_done_r;
    head_pop      = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = ADDR_W'({s_r, j_r});
    ram_wdata     = seed_w;
    st_we         = 1'b0;
    carry_set     = c_fix;
    idx_set       = gidx_r;

    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          s_nxt    = head_cmd.stream;
          case (head_cmd.op)
            OP_SEED: begin
              ram_we    = 1'b1;
              ram_addr  = ADDR_W'({head_cmd.stream, IDX_W'(0)});
              ram_wdata = head_cmd.seed;
              w_nxt     = head_cmd.seed;
              j_nxt     = IDX_W'(1);
              state_nxt = ST_SEED_MUL;
            end
            OP_GEN: begin
              ram_addr  = ADDR_W'({head_cmd.stream, next_idx});
              gidx_nxt  = next_idx;
              state_nxt = ST_GEN_MUL;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '0;
              out_seed_nxt  = 1'b0;
            end
          endcase
        end
      end
      ST_SEED_MUL: begin
        p_nxt     = mul_lo;
        state_nxt = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        ram_we    = 1'b1;
        ram_addr  = ADDR_W'({s_r, j_r});
        ram_wdata = seed_w;
        w_nxt     = seed_w;
        if (j_r == LAG_MASK) begin
          state_nxt = ST_SEED_MOD;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_SEED_MOD: begin
        // quotient is at most five, so subtract until below the modulus
        if (w_r >= CARRY_MOD) begin
          w_nxt = w_r - CARRY_MOD;
        end else begin
          st_we         = 1'b1;
          carry_set     = w_r;
          idx_set       = LAG_MASK;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_seed_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_GEN_MUL: begin
        prod_nxt  = PROD_W'(GEN_MULT) * PROD_W'(ram_rdata);
        state_nxt = ST_GEN_ADD;
      end
      ST_GEN_ADD: begin
        t_nxt     = prod_r + PROD_W'(carry_r[s_r]);
        state_nxt = ST_GEN_FIN;
      end
      ST_GEN_FIN: begin
        ram_we        = 1'b1;
        ram_addr      = ADDR_W'({s_r, gidx_r});
        ram_wdata     = gen_word;
        st_we         = 1'b1;
        carry_set     = c_fix;
        idx_set       = gidx_r;
        out_valid_nxt = 1'b1;
        out_word_nxt  = gen_word;
        out_seed_nxt  = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STREAMS; i++) begin
        carry_r[i]   <= '0;
        lag_idx_r[i] <= LAG_MASK;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (st_we) begin
        carry_r[s_r]   <= carry_set;
        lag_idx_r[s_r] <= idx_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r               <= s_nxt;
    w_r               <= w_nxt;
    p_r               <= p_nxt;
    j_r               <= j_nxt;
    gidx_r            <= gidx_nxt;
    prod_r            <= prod_nxt;
    t_r               <= t_nxt;
    out_random_word_r <= out_word_nxt;
    out_seed_done_r   <= out_seed_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_random_word_r;
  assign out_seed_done   = out_seed_done_r;

  `CMWC_ASSERT_NOW(a_pop_has_head, head_pop, head_valid, "pop from an empty command queue")
  `CMWC_ASSERT_NEXT(a_seed_walk_end,
    (state_r == ST_SEED_ADD) && (j_r == LAG_MASK), state_r == ST_SEED_MOD,
    "seed walk did not reach the carry reduction")
  `CMWC_ASSERT_NEXT(a_seed_ack,
    (state_r == ST_SEED_MOD) && (w_r < CARRY_MOD),
    out_valid_r && out_seed_done_r && (out_random_word_r == '0),
    "seed finished without a clean acknowledge beat")
  `CMWC_ASSERT_NEXT(a_gen_beat,
    state_r == ST_GEN_FIN, out_valid_r && !out_seed_done_r && (state_r == ST_IDLE),
    "generate finished without a word beat")

endmodule

`default_nettype wire

[hdl/cmwc4096_random_generator.sv]
`timescale 1ns / 1ps
`default_nettype none

// generate: a queued command waits until the back end is idle, which then reads, multiplies,
//   adds and writes back on the lag table; the result strobe is registered with the write-back
// seed: a multiply and an add step per table word, then the carry reduction by subtraction
// a two-entry command queue lets start be taken while the back end works; results
//   cannot be stalled. reset clears control, carries to zero and indices to 4095;
//   the lag table is not cleared and busy is low right after reset

module cmwc4096_random_generator (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_req_type,
  input  wire  [1:0]  in_stream_id,
  input  wire  [31:0] in_seed_value,
  output logic        out_valid,
  output logic [31:0] out_random_word,
  output logic        out_seed_done
);

  import cmwc_pkg::*;

  logic head_valid;
  cmd_t head_cmd;
  logic head_pop;

  cmwc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_stream_id  (in_stream_id),
    .in_seed_value (in_seed_value),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .head_pop      (head_pop)
  );

  cmwc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .head_pop        (head_pop),
    .out_valid       (out_valid),
    .out_random_word (out_random_word),
    .out_seed_done   (out_seed_done)
  );

endmodule

`default_nettype wire

[dv/tb_cmwc4096_random_generator.sv]
`timescale 1ns / 1ps

module tb_cmwc4096_random_generator;
  import cmwc_pkg::*;

  localparam logic REQ_GEN  = 1'b0;
  localparam logic REQ_SEED = 1'b1;

  localparam int DIR_ROWS    = 20;
  localparam int RAND_ITEMS  = 700;
  localparam int QUIET_TAIL  = 100;
  localparam int DRAIN_WAIT  = 20;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    logic        word_ok;
    logic [31:0] word;
    logic        done;
  } result_t;

  typedef struct {
    logic        req;
    logic [1:0]  sid;
    logic [31:0] seed;
    bit          typed;
    logic [31:0] word;
    logic        done;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_req_type = 1'b0;
  logic [1:0]  in_stream_id = 2'd0;
  logic [31:0] in_seed_value = 32'd0;
  wire         busy;
  wire         out_valid;
  wire  [31:0] out_random_word;
  wire         out_seed_done;

  // private copy of the generator state
  logic [31:0] lag_mem [STREAMS][LAG_LEN];
  logic [31:0] carry_reg [STREAMS];
  logic [11:0] lag_ptr [STREAMS];

  result_t     expected_q [$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  stim_row_t   dir_tab [DIR_ROWS];

  cmwc4096_random_generator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_stream_id    (in_stream_id),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_random_word (out_random_word),
    .out_seed_done   (out_seed_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void fill_lag_table(int s, logic [31:0] seed);
    logic [31:0] w;
    w = seed;
    lag_mem[s][0] = w;
    for (int j = 1; j < LAG_LEN; j++) begin
      w = INIT_MULT * (w ^ (w >> INIT_SHIFT)) + 32'(j);
      lag_mem[s][j] = w;
    end
    carry_reg[s] = w % CARRY_MOD;
    lag_ptr[s] = LAG_MASK;
  endfunction

  function automatic logic [31:0] next_cmwc_word(int s);
    logic [11:0] i;
    logic [63:0] t;
    logic [31:0] c;
    logic [31:0] x;
    logic [31:0] r;
    i = lag_ptr[s] + 12'd1;
    t = 64'(GEN_MULT) * 64'(lag_mem[s][i]) + 64'(carry_reg[s]);
    c = t[63:32];
    x = t[31:0] + c;
    // carry fixup when the add wrapped
    if (x < c) begin
      x = x + 32'd1;
      c = c + 32'd1;
    end
    r = GEN_R - x;
    lag_ptr[s] = i;
    carry_reg[s] = c;
    lag_mem[s][i] = r;
    return r;
  endfunction

  function automatic result_t predict_result(logic req, logic [1:0] sid, logic [31:0] seed);
    result_t res;
    res.word_ok = 1'b1;
    if (req == REQ_SEED) begin
      fill_lag_table(int'(sid), seed);
      res.word = 32'd0;
      res.done = 1'b1;
    end else begin
      res.word = next_cmwc_word(int'(sid));
      res.done = 1'b0;
    end
    return res;
  endfunction

  // one command beat; gap cycles of idling first, then hold until taken
  task automatic send_cmd(int gap, stim_row_t row);
    result_t res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type   <= row.req;
    in_stream_id  <= row.sid;
    in_seed_value <= row.seed;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    res = predict_result(row.req, row.sid, row.seed);
    if (row.typed) begin
      res.word = row.word;
      res.done = row.done;
    end
    expected_q.push_back(res);
  endtask

  function automatic int pick_gap(bit quiet);
    if (quiet || $urandom_range(0, 9) > 2)
      return 0;
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result beat", out_random_word, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_random_word !== want.word)
          report_mismatch("random_word", out_random_word, want.word);
        if (out_seed_done !== want.done)
          report_mismatch("seed_done", 32'(out_seed_done), 32'(want.done));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL cmwc4096_random_generator");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    int        roll;

    for (int s = 0; s < STREAMS; s++) begin
      carry_reg[s] = 32'd0;
      lag_ptr[s]   = LAG_MASK;
    end

    // every stream is seeded before its first generate
    dir_tab = '{
      '{REQ_SEED, 2'd0, 32'h0000_0000, 1'b1, 32'd0, 1'b1},
      '{REQ_SEED, 2'd1, 32'hffff_ffff, 1'b1, 32'd0, 1'b1},
      '{REQ_SEED, 2'd2, 32'h8000_0000, 1'b1, 32'd0, 1'b1},
      '{REQ_SEED, 2'd3, 32'h0000_0001, 1'b1, 32'd0, 1'b1},
      '{REQ_GEN,  2'd0, 32'hffff_ffff, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd1, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd2, 32'ha5a5_a5a5, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd3, 32'h5a5a_5a5a, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd0, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd0, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd0, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd1, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd2, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd3, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_SEED, 2'd0, 32'h1234_5678, 1'b1, 32'd0, 1'b1},
      '{REQ_GEN,  2'd0, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd0, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{REQ_SEED, 2'd3, 32'hffff_ffff, 1'b1, 32'd0, 1'b1},
      '{REQ_GEN,  2'd3, 32'hffff_ffff, 1'b0, 32'd0, 1'b0},
      '{REQ_GEN,  2'd2, 32'h0000_0000, 1'b0, 32'd0, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_ROWS; k++)
      send_cmd(pick_gap(1'b0), dir_tab[k]);

    for (int k = 0; k < RAND_ITEMS; k++) begin
      row.typed = 1'b0;
      row.word  = 32'd0;
      row.done  = 1'b0;
      row.sid   = 2'($urandom_range(0, 3));
      // seeding walks the whole lag table, so keep it rare
      row.req   = ($urandom_range(0, 99) < 5) ? REQ_SEED : REQ_GEN;
      roll      = $urandom_range(0, 7);
      if (roll == 0)
        row.seed = 32'h0000_0000;
      else if (roll == 1)
        row.seed = 32'hffff_ffff;
      else
        row.seed = $urandom;
      send_cmd(pick_gap(k >= RAND_ITEMS - QUIET_TAIL), row);
    end
    start <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0)
      $display("PASS cmwc4096_random_generator");
    else
      $display("FAIL cmwc4096_random_generator");
    $finish;
  end

endmodule

[cmwc4096_random_generator.f]
+incdir+hdl
hdl/cmwc_pkg.sv
hdl/cmwc_ram.sv
hdl/cmwc_front.sv
hdl/cmwc_back.sv
hdl/cmwc4096_random_generator.sv
dv/tb_cmwc4096_random_generator.sv
